/* rtl/core/lrs_pkg.sv */
// Shared types, constants and helpers for the linear regression SGD trainer.
// Used by every file in rtl/core but lrs_ram; depends on nothing else.
package lrs_pkg;

  // Field widths of the channels.
  localparam int DATA_W     = 16;  // Q3.12 samples
  localparam int COEF_W     = 32;  // Q7.24 coefficients and error
  localparam int IDX_W      = 4;   // coefficient index on the result channel
  localparam int NF_W       = 4;   // num_features register
  localparam int LR_W       = 24;  // learning_rate register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Internal arithmetic widths.
  localparam int ACC_W   = 48;  // prediction sum, Q23.24
  localparam int DELTA_W = 36;  // weight decrement after the 12-bit shift
  localparam int SLOT_W  = 6;   // feature slot, wide enough for the largest buffer

  localparam int MAX_FEATURES_DEFAULT = 15;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [NF_W-1:0] NUM_FEATURES_RESET  = 4'd11;
  localparam logic [LR_W-1:0] LEARNING_RATE_RESET = 24'd16777;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_FEATURES  = 2'd0,
    CFG_LEARNING_RATE = 2'd1
  } cfg_reg_t;

  // Classification of an accepted item.
  typedef enum logic [1:0] {
    OP_FEATURE = 2'd0,  // feature to buffer and accumulate
    OP_SKIP    = 2'd1,  // surplus feature, only its clear takes effect
    OP_TARGET  = 2'd2   // target, ends the row
  } op_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_MAC  = 3'd1,
    ST_ERR  = 3'd2,
    ST_STEP = 3'd3,
    ST_MUL  = 3'd4,
    ST_UPD  = 3'd5
  } state_t;

  // Command passed from the front end to the back end.
  typedef struct packed {
    op_t                       op;
    logic                      clear;
    logic signed [DATA_W-1:0]  value;
    logic [SLOT_W-1:0]         slot;
    logic                      ok;
  } cmd_t;

  // Clamp a wide signed value to the 32-bit coefficient range.
  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [COEF_W-1:0] r;
    if (v > 64'(COEF_MAX)) begin
      r = COEF_MAX;
    end else if (v < 64'(COEF_MIN)) begin
      r = COEF_MIN;
    end else begin
      r = v[COEF_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/lrs_sample_if.sv */
// Input channel of the trainer: one sample per transfer.
// Depends on lrs_pkg for the field widths.
interface lrs_sample_if import lrs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample_value;
  logic                     is_target;
  logic                     clear_first;

  modport source (output valid, sample_value, is_target, clear_first, input ready);
  modport sink   (input valid, sample_value, is_target, clear_first, output ready);
endinterface

/* rtl/core/lrs_coef_if.sv */
// Result channel of the trainer: one coefficient per transfer.
// Depends on lrs_pkg for the field widths.
interface lrs_coef_if import lrs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic signed [COEF_W-1:0] row_error;
  logic                     row_ok;
  logic                     last_of_run;

  modport source (output valid, coef_index, coef_value, row_error, row_ok, last_of_run,
                  input ready);
  modport sink   (input valid, coef_index, coef_value, row_error, row_ok, last_of_run,
                  output ready);
endinterface

/* rtl/core/lrs_cfg_if.sv */
// Configuration write channel: register index and write data per transfer.
// Depends on lrs_pkg for the field widths.
interface lrs_cfg_if import lrs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/lrs_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module lrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/lrs_front.sv */
// Front end: takes sample transfers, keeps the feature count of the open row
// and turns each sample into a command for the queue. Depends on lrs_pkg.
module lrs_front import lrs_pkg::*; #(
  parameter int MAX_FEATURES = MAX_FEATURES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  lrs_sample_if.sink      sample,
  input  logic [NF_W-1:0] num_features,
  input  logic            q_full,
  output logic            push,
  output cmd_t            push_cmd
);

  localparam int CNT_W = $clog2(MAX_FEATURES + 2);
  localparam int CMP_W = (CNT_W > NF_W) ? CNT_W : NF_W;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             has_room;

  // A sample is taken whenever the queue has space.
  assign sample.ready = !q_full;
  assign push         = sample.valid && sample.ready;
  assign has_room     = count < CNT_W'(MAX_FEATURES);

  // Classify the sample and work out the new feature count.
  always_comb begin
    push_cmd.clear = sample.clear_first;
    push_cmd.value = sample.sample_value;
    push_cmd.slot  = SLOT_W'(count);
    push_cmd.ok    = CMP_W'(count) == CMP_W'(num_features);
    if (sample.is_target) begin
      push_cmd.op = OP_TARGET;
      count_next  = '0;
    end else if (has_room) begin
      push_cmd.op = OP_FEATURE;
      count_next  = count + CNT_W'(1);
    end else begin
      // Surplus feature: the count sticks one above the buffer size.
      push_cmd.op = OP_SKIP;
      count_next  = CNT_W'(MAX_FEATURES + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count_next;
    end
  end

endmodule

/* rtl/core/lrs_queue.sv */
// Short command queue between the front end and the back end.
// Depends on lrs_pkg for the command type and depth.
module lrs_queue import lrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int UW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [UW-1:0] used;

  assign full    = used == UW'(QUEUE_DEPTH);
  assign q_valid = used != '0;
  assign q_cmd   = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        used <= used + UW'(1);
      end else if (pop && !push) begin
        used <= used - UW'(1);
      end
    end
  end

endmodule

/* rtl/core/lrs_back.sv */
// Back end: carries out queued commands against the coefficient store and the
// feature buffer and drives the result register. Depends on lrs_pkg, lrs_ram.
module lrs_back import lrs_pkg::*; #(
  parameter int MAX_FEATURES = MAX_FEATURES_DEFAULT,
  localparam int CA_W        = $clog2(MAX_FEATURES + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  cmd_t            q_cmd,
  output logic            q_pop,
  input  logic [LR_W-1:0] learning_rate,
  input  logic [CA_W-1:0] run_last,
  lrs_coef_if.source      coef
);

  localparam int FA_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int NC   = MAX_FEATURES + 1;

  state_t state, state_next;

  // Valid bit per coefficient: an entry not valid reads as zero.
  logic [NC-1:0] valid;
  logic          rd_ok;

  logic [CA_W-1:0]           k;
  logic                      row_ok;
  logic                      is_last;
  logic signed [DATA_W-1:0]  x_q;
  logic signed [ACC_W-1:0]   acc;
  logic signed [COEF_W-1:0]  err;
  logic signed [COEF_W-1:0]  step;
  logic signed [COEF_W-1:0]  coef_q;
  logic signed [DELTA_W-1:0] delta;

  // Memory ports.
  logic              coef_we, coef_re;
  logic [CA_W-1:0]   coef_raddr;
  logic [COEF_W-1:0] coef_rdata;
  logic              fbuf_we, fbuf_re;
  logic [FA_W-1:0]   fbuf_waddr, fbuf_raddr;
  logic [DATA_W-1:0] fbuf_rdata;

  // Arithmetic.
  logic signed [COEF_W-1:0]    coef_rd;
  logic signed [DATA_W-1:0]    feat_rd;
  logic signed [47:0]          mac_prod;
  logic signed [35:0]          mac_sh;
  logic signed [49:0]          err_full;
  logic signed [56:0]          step_prod;
  logic signed [47:0]          upd_prod;
  logic signed [DELTA_W:0]     upd_diff;
  logic signed [COEF_W-1:0]    new_coef;

  // Result register.
  logic                     out_valid;
  logic                     out_free;
  logic                     out_load;
  logic [IDX_W-1:0]         out_index;
  logic signed [COEF_W-1:0] out_value;
  logic signed [COEF_W-1:0] out_err;
  logic                     out_ok;
  logic                     out_last;

  lrs_ram #(.WIDTH(COEF_W), .DEPTH(NC)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (k),
    .wdata (new_coef),
    .re    (coef_re),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  lrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_FEATURES)) u_fbuf_ram (
    .clk   (clk),
    .we    (fbuf_we),
    .waddr (fbuf_waddr),
    .wdata (q_cmd.value),
    .re    (fbuf_re),
    .raddr (fbuf_raddr),
    .rdata (fbuf_rdata)
  );

  assign is_last    = k == run_last;
  assign out_free   = !out_valid || coef.ready;
  assign fbuf_waddr = q_cmd.slot[FA_W-1:0];
  assign fbuf_raddr = FA_W'(k);

  // Datapath arithmetic.
  assign coef_rd   = rd_ok ? $signed(coef_rdata) : '0;
  assign feat_rd   = $signed(fbuf_rdata);
  assign mac_prod  = coef_rd * x_q;
  assign mac_sh    = mac_prod[47:12];
  assign err_full  = 50'(acc) + 50'(coef_rd) - (50'(x_q) <<< 12);
  assign step_prod = $signed({1'b0, learning_rate}) * err;
  assign upd_prod  = step * feat_rd;
  assign upd_diff  = (DELTA_W + 1)'(coef_q) - (DELTA_W + 1)'(delta);
  assign new_coef  = row_ok ? sat32(64'(upd_diff)) : coef_q;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_FEATURE: state_next = ST_MAC;
            OP_TARGET:  state_next = ST_ERR;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_MAC:  state_next = ST_IDLE;
      ST_ERR:  state_next = ST_STEP;
      ST_STEP: state_next = ST_MUL;
      ST_MUL:  state_next = ST_UPD;
      ST_UPD: begin
        if (out_free) begin
          state_next = is_last ? ST_IDLE : ST_MUL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs per state.
  always_comb begin
    q_pop      = 1'b0;
    coef_re    = 1'b0;
    coef_raddr = '0;
    coef_we    = 1'b0;
    fbuf_we    = 1'b0;
    fbuf_re    = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        q_pop = q_valid;
        if (q_valid && q_cmd.op == OP_FEATURE) begin
          coef_re    = 1'b1;
          coef_raddr = CA_W'(q_cmd.slot) + CA_W'(1);
          fbuf_we    = 1'b1;
        end else if (q_valid && q_cmd.op == OP_TARGET) begin
          coef_re    = 1'b1;
        end
      end
      ST_MUL: begin
        // Fetch the next coefficient and its feature while this one is updated.
        if (!is_last) begin
          coef_re    = 1'b1;
          coef_raddr = k + CA_W'(1);
          fbuf_re    = 1'b1;
        end
      end
      ST_UPD: begin
        out_load = out_free;
        coef_we  = out_free && row_ok;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Control registers: state, valid bits, accumulator, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      rd_ok     <= 1'b0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop && q_cmd.clear) begin
        valid <= '0;
      end
      if (coef_we) begin
        valid[k] <= 1'b1;
      end
      if (coef_re) begin
        rd_ok <= valid[coef_raddr] && !(q_pop && q_cmd.clear);
      end
      if (state == ST_MAC) begin
        acc <= acc + ACC_W'(mac_sh);
      end else if (state == ST_ERR) begin
        acc <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (coef.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_q    <= q_cmd.value;
      row_ok <= q_cmd.ok;
      k      <= '0;
    end
    if (state == ST_ERR) begin
      err <= row_ok ? sat32(64'(err_full)) : '0;
    end
    if (state == ST_STEP) begin
      step <= step_prod[55:24];
    end
    if (state == ST_MUL) begin
      coef_q <= coef_rd;
      delta  <= (k == '0) ? DELTA_W'(step) : upd_prod[47:12];
    end
    if (out_load) begin
      out_index <= IDX_W'(k);
      out_value <= new_coef;
      out_err   <= err;
      out_ok    <= row_ok;
      out_last  <= is_last;
      if (!is_last) begin
        k <= k + CA_W'(1);
      end
    end
  end

  assign coef.valid       = out_valid;
  assign coef.coef_index  = out_index;
  assign coef.coef_value  = out_value;
  assign coef.row_error   = out_err;
  assign coef.row_ok      = out_ok;
  assign coef.last_of_run = out_last;

endmodule

/* rtl/core/linear_regression_sgd_update.sv */
// Top level of the linear regression SGD trainer with its configuration registers.
// Depends on lrs_pkg, the three channel interfaces, lrs_front, lrs_queue, lrs_back.
//
// Usage:
//   sample  - training items: a row is num_features feature samples followed by
//             one sample with is_target set; clear_first zeroes all coefficients
//             before the item is handled.
//   coef    - on each target, one transfer per coefficient from the bias up to
//             index num_features (capped at MAX_FEATURES), last_of_run on the
//             final one, each carrying the row error and whether it was applied.
//   cfg     - register writes, always ready, index 0 num_features, 1 learning_rate.
// Flow: a sample enters a two-entry command queue in the cycle it is
// transferred. The back end handles a feature in the IDLE and MAC states, a
// surplus feature in IDLE alone and a target in IDLE, ERR and STEP followed by
// MUL and UPD for each coefficient, reading through the single read port of
// the coefficient RAM. The first coefficient of a run is loaded into the result
// register in UPD, after the target has passed IDLE, ERR, STEP and MUL. A
// stalled receiver holds the result register and the back end; the queue keeps
// taking samples until it is full. Reset clears the coefficients, the row
// state and the registers to their defaults (11 features, rate 16777 / 2^24).
module linear_regression_sgd_update import lrs_pkg::*; #(
  parameter int MAX_FEATURES = MAX_FEATURES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  lrs_sample_if.sink   sample,
  lrs_coef_if.source   coef,
  lrs_cfg_if.sink      cfg
);

  localparam int CA_W  = $clog2(MAX_FEATURES + 1);
  localparam int CMP_W = (CA_W > NF_W) ? CA_W : NF_W;

  logic [NF_W-1:0] num_features;
  logic [LR_W-1:0] learning_rate;
  logic [CA_W-1:0] run_last;
  logic            push;
  cmd_t            push_cmd;
  logic            q_full;
  logic            q_valid;
  cmd_t            q_cmd;
  logic            q_pop;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_features  <= NUM_FEATURES_RESET;
      learning_rate <= LEARNING_RATE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_NUM_FEATURES:  num_features  <= cfg.data[NF_W-1:0];
        CFG_LEARNING_RATE: learning_rate <= cfg.data[LR_W-1:0];
        default: begin
          num_features <= num_features;
        end
      endcase
    end
  end

  // Index of the last coefficient of a run, limited by the store size.
  always_comb begin
    if (CMP_W'(num_features) > CMP_W'(MAX_FEATURES)) begin
      run_last = CA_W'(MAX_FEATURES);
    end else begin
      run_last = CA_W'(num_features);
    end
  end

  lrs_front #(.MAX_FEATURES(MAX_FEATURES)) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .num_features (num_features),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  lrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (q_pop)
  );

  lrs_back #(.MAX_FEATURES(MAX_FEATURES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .learning_rate (learning_rate),
    .run_last      (run_last),
    .coef          (coef)
  );

`ifndef SYNTHESIS
  // A run ends exactly at the configured last coefficient.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    coef.valid && coef.last_of_run |-> coef.coef_index == IDX_W'(run_last))
    else $error("last_of_run on wrong coefficient index");

  // No coefficient beyond the run is emitted.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    coef.valid |-> coef.coef_index <= IDX_W'(run_last))
    else $error("coefficient index beyond run");

  // A row without an update reports no error.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    coef.valid && !coef.row_ok |-> coef.row_error == '0)
    else $error("row error reported on a mismatched row");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !coef.valid)
    else $error("result valid after reset");
`endif

endmodule
